// ===== rtl/ots_pkg.sv =====
// ----------------------------------------------------------------------------
// ots_pkg
// shared types for the odd-even transposition sorter: request and result
// payloads and the controller-to-datapath command group
// ----------------------------------------------------------------------------
package ots_pkg;

  localparam int unsigned KeyW = 32;

  // one request: a key and the end-of-set mark
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last;
  } req_t;

  // one result: next key in ascending order plus flags
  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic            final_res;
    logic            overflow;
  } res_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store the request key or flag it as dropped
    logic sort;       // run one compare-exchange phase
    logic odd_pairs;  // phase works on pairs starting at odd positions
    logic shift;      // move all keys one position toward position 0
    logic clear;      // end of set: count and dropped flag back to zero
  } cmd_t;

endpackage

// ===== rtl/ots_datapath.sv =====
// ----------------------------------------------------------------------------
// ots_datapath
// row of key cells with parallel compare-exchange, key count and dropped
// flag; results leave from position 0 while the row shifts down
// ----------------------------------------------------------------------------
module ots_datapath import ots_pkg::*; #(
  parameter int unsigned MAX_KEYS = 16,
  parameter int unsigned CntW     = $clog2(MAX_KEYS + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic [KeyW-1:0] key_i,
  output logic [CntW-1:0] count_o,
  output logic [KeyW-1:0] head_key_o,
  output logic            dropped_o
);

  localparam int unsigned IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  logic [KeyW-1:0] cells_q [MAX_KEYS];
  logic [KeyW-1:0] cells_d [MAX_KEYS];
  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;
  logic            full;

  assign full = (count_q == CntW'(MAX_KEYS));

  // cell row: load at the fill position, one phase of swaps, or shift out
  always_comb begin
    cells_d = cells_q;
    if (cmd_i.load && !full) begin
      cells_d[count_q[IdxW-1:0]] = key_i;
    end
    if (cmd_i.sort) begin
      for (int pos = 0; pos < int'(MAX_KEYS) - 1; pos++) begin
        if ((((pos & 1) == 1) == cmd_i.odd_pairs) &&
            (CntW'(pos + 1) < count_q) &&
            (cells_q[pos] > cells_q[pos+1])) begin
          cells_d[pos]   = cells_q[pos+1];
          cells_d[pos+1] = cells_q[pos];
        end
      end
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < int'(MAX_KEYS) - 1; i++) begin
        cells_d[i] = cells_q[i+1];
      end
    end
  end

  // key count and dropped flag
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.load) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
    if (cmd_i.clear) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end
  end

  // cells carry payload only
  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  assign count_o    = count_q;
  assign head_key_o = cells_q[0];
  assign dropped_o  = dropped_q;

endmodule

// ===== rtl/ots_ctrl.sv =====
// ----------------------------------------------------------------------------
// ots_ctrl
// controller: takes requests while idle, sequences one compare-exchange
// phase per cycle, then strobes one result per cycle
// ----------------------------------------------------------------------------
module ots_ctrl import ots_pkg::*; #(
  parameter int unsigned MAX_KEYS = 16,
  parameter int unsigned CntW     = $clog2(MAX_KEYS + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            last_i,
  input  logic [CntW-1:0] count_i,
  output logic            busy,
  output cmd_t            cmd_o,
  output logic            strobe_o,
  output logic            final_o
);

  typedef enum logic [1:0] {
    IDLE,
    SORT,
    EMIT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] phase_q;
  logic [CntW-1:0] rem_q;
  logic            accept;

  assign accept = start && (state_q == IDLE);

  // state, phase counter and results still to go
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      phase_q <= '0;
      rem_q   <= '0;
    end else begin
      unique case (state_q)
        IDLE: begin
          if (accept && last_i) begin
            state_q <= SORT;
            phase_q <= '0;
          end
        end
        SORT: begin
          if (phase_q == count_i - CntW'(1)) begin
            state_q <= EMIT;
            rem_q   <= count_i;
          end else begin
            phase_q <= phase_q + CntW'(1);
          end
        end
        EMIT: begin
          rem_q <= rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.sort      = (state_q == SORT);
    cmd_o.odd_pairs = ~phase_q[0];
    cmd_o.shift     = (state_q == EMIT);
    cmd_o.clear     = (state_q == EMIT) && (rem_q == CntW'(1));
  end

  assign busy     = (state_q != IDLE);
  assign strobe_o = (state_q == EMIT);
  assign final_o  = (state_q == EMIT) && (rem_q == CntW'(1));

  // the final result returns the controller to idle
  a_final_ends_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_o |=> !busy)
    else $error("final result did not end the set");

  // a last request starts the sort
  a_last_starts_sort : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> (state_q == SORT))
    else $error("last request did not start sorting");

  // never more results than stored keys
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ((rem_q != '0) && (rem_q <= count_i)))
    else $error("result count out of range");

  // sort phases never run past the stored key count
  a_phase_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SORT) |-> (phase_q < count_i))
    else $error("phase counter past key count");

endmodule

// ===== rtl/odd_even_transposition_sorter.sv =====
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter
// collects a set of unsigned Q0.32 keys and returns them in ascending order
// after as many odd-even compare-exchange phases as there are keys
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  request   in         start, busy         req_i  (key, last)
//  result    out        res_strobe_o        res_o  (sorted_key, final_res,
//                                                   overflow)
//
//  a request is taken while idle; on a last request the block stays busy
//  for n sort phases (one phase per cycle across the key row) and then
//  strobes n results, n being the stored keys, up to MAX_KEYS
//  each result is shown for one cycle only; the receiver cannot stall
//  reset clears count, dropped flag and controller; key cells need none
// ----------------------------------------------------------------------------
module odd_even_transposition_sorter import ots_pkg::*; #(
  parameter int unsigned MAX_KEYS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_strobe_o,
  output res_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_KEYS + 1);

  cmd_t            cmd;
  logic [CntW-1:0] count;
  logic [KeyW-1:0] head_key;
  logic            dropped;
  logic            final_res;

  // sequencing
  ots_ctrl #(
    .MAX_KEYS (MAX_KEYS),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .last_i   (req_i.last),
    .count_i  (count),
    .busy     (busy),
    .cmd_o    (cmd),
    .strobe_o (res_strobe_o),
    .final_o  (final_res)
  );

  // key row
  ots_datapath #(
    .MAX_KEYS (MAX_KEYS),
    .CntW     (CntW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .key_i      (req_i.key),
    .count_o    (count),
    .head_key_o (head_key),
    .dropped_o  (dropped)
  );

  // result assembly
  always_comb begin
    res_o.sorted_key = head_key;
    res_o.final_res  = final_res;
    res_o.overflow   = dropped;
  end

endmodule
